### design/greedy_box_nms_top_defines.svh
// Assertion macros shared by the checker of the greedy box NMS block.
// No dependencies; included by the checker file.
`ifndef GREEDY_BOX_NMS_TOP_DEFINES_SVH
`define GREEDY_BOX_NMS_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GBN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GBN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/gbn_pkg.sv
// Package for the greedy box NMS block: sizes and box arithmetic helpers.
// No dependencies; imported by the top level.
package gbn_pkg;

  localparam int MAX_BOXES  = 64;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_BOXES);
  localparam int CNT_W      = $clog2(MAX_BOXES + 1);

  // Keep the low COORD_BITS bits of a corner and sign-extend them to 16 bits.
  function automatic logic [15:0] norm_coord(input logic [15:0] raw);
    logic signed [15:0] t;
    t = $signed(raw << (16 - COORD_BITS));
    return 16'(t >>> (16 - COORD_BITS));
  endfunction

  // hi - lo, clamped at zero.
  function automatic logic [15:0] span(input logic signed [15:0] lo,
                                       input logic signed [15:0] hi);
    logic signed [16:0] d;
    d = {hi[15], hi} - {lo[15], lo};
    return d[16] ? 16'd0 : d[15:0];
  endfunction

endpackage

### design/greedy_box_nms_top.sv
// Greedy non-maximum suppression over a batch of boxes held in two memories.
// Depends on gbn_pkg.
//
// Usage: boxes enter on the s_axis channel, one item per cycle while loading;
// tlast closes the batch. Up to MAX_BOXES boxes are stored; later boxes of the
// batch are dropped and every result of that batch carries tuser (truncated).
// After the closing item the input stalls while the batch is processed:
// for each kept box one pass over the score memory picks the best remaining
// box, one read fetches its corners, and one pass over the corner memory
// through the pipelined IoU compare marks suppressed boxes. The work for a
// batch is thus quadratic in the number of boxes in the worst case.
// Results leave on m_axis one per kept box in suppression order, tlast on the
// last one. A kept box is emitted when the next survivor is found or the
// batch ends, so a stalled receiver only holds the block when a second
// result is waiting. Registers are to be written over APB only while idle;
// the block itself does not enforce it. Reset clears all control state, the
// counters and the suppression flags; the threshold returns to 0.5 and presorted to zero.
module greedy_box_nms_top
  import gbn_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // left_x[15:0], top_y[31:16], right_x[47:32], bottom_y[63:48], confidence[79:64]
  input  logic [79:0]  s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // kept_left_x[15:0], kept_top_y[31:16], kept_right_x[47:32],
  // kept_bottom_y[63:48], kept_confidence[79:64]
  output logic [79:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  // truncated[0]
  output logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [2:0] ADDR_THR     = 3'd0;
  localparam logic [2:0] ADDR_PRESORT = 3'd4;

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_FETCH  = 3'd3;
  localparam logic [2:0] ST_FWAIT  = 3'd4;
  localparam logic [2:0] ST_SUP    = 3'd5;
  localparam logic [2:0] ST_SDRAIN = 3'd6;
  localparam logic [2:0] ST_FINAL  = 3'd7;

  logic [2:0]           state;
  logic [16:0]          thr;
  logic                 presorted;
  logic [CNT_W-1:0]     box_count;
  logic [CNT_W-1:0]     cnt;
  logic                 overflow_seen;
  logic [MAX_BOXES-1:0] done;

  logic [63:0] coord_mem [MAX_BOXES];
  logic [15:0] score_mem [MAX_BOXES];

  logic             sc_re, sc_v;
  logic [IDX_W-1:0] sc_addr, sc_idx;
  logic [15:0]      sc_rdata;
  logic             cd_re, cd_v;
  logic [IDX_W-1:0] cd_addr, cd_idx;
  logic [63:0]      cd_rdata;

  logic             found;
  logic [IDX_W-1:0] best_idx;
  logic [15:0]      best_score;

  logic             pend_v;
  logic [63:0]      pend_coord;
  logic [15:0]      pend_score;

  logic             out_free, out_load, s_acc, cfg_wr;

  // IoU pipeline
  logic             p1_v, p2_v, p3_v;
  logic [IDX_W-1:0] p1_idx, p2_idx, p3_idx;
  logic [15:0]      iw, ih, aw, ah, bw, bh;
  logic [31:0]      inter2, area_a, area_b, inter3;
  logic [32:0]      uni;
  logic             over;

  logic signed [15:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;

  assign pready        = 1'b1;
  assign cfg_wr        = psel & penable & pwrite & pready;
  assign s_axis_tready = (state == ST_LOAD);
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = ((state == ST_FWAIT) && pend_v && out_free) ||
                         ((state == ST_FINAL) && out_free);

  always_comb begin
    case (paddr)
      ADDR_THR:     prdata = {15'd0, thr};
      ADDR_PRESORT: prdata = {31'd0, presorted};
      default:      prdata = 32'd0;
    endcase
  end

  assign sc_re   = (state == ST_SCAN) && (cnt < box_count);
  assign sc_addr = cnt[IDX_W-1:0];
  assign cd_re   = (state == ST_FETCH) || ((state == ST_SUP) && (cnt < box_count));
  assign cd_addr = (state == ST_FETCH) ? best_idx : cnt[IDX_W-1:0];

  // Memories: one write port used while loading, one registered read port each.
  always_ff @(posedge clk) begin
    if (s_acc && (box_count < CNT_W'(MAX_BOXES))) begin
      coord_mem[box_count[IDX_W-1:0]] <= {norm_coord(s_axis_tdata[63:48]),
                                          norm_coord(s_axis_tdata[47:32]),
                                          norm_coord(s_axis_tdata[31:16]),
                                          norm_coord(s_axis_tdata[15:0])};
      score_mem[box_count[IDX_W-1:0]] <= s_axis_tdata[79:64];
    end
    if (sc_re) begin
      sc_rdata <= score_mem[sc_addr];
    end
    if (cd_re) begin
      cd_rdata <= coord_mem[cd_addr];
    end
  end

  assign ax1 = $signed(pend_coord[15:0]);
  assign ay1 = $signed(pend_coord[31:16]);
  assign ax2 = $signed(pend_coord[47:32]);
  assign ay2 = $signed(pend_coord[63:48]);
  assign bx1 = $signed(cd_rdata[15:0]);
  assign by1 = $signed(cd_rdata[31:16]);
  assign bx2 = $signed(cd_rdata[47:32]);
  assign by2 = $signed(cd_rdata[63:48]);

  // Union zero or no overlap gives inter zero, so the strict compare fails.
  assign over = ({2'd0, inter3, 16'd0} > (50'(thr) * 50'(uni)));

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    sc_idx <= sc_addr;
    cd_idx <= cd_addr;
    p1_idx <= cd_idx;
    p2_idx <= p1_idx;
    p3_idx <= p2_idx;
    iw <= span((ax1 > bx1) ? ax1 : bx1, (ax2 < bx2) ? ax2 : bx2);
    ih <= span((ay1 > by1) ? ay1 : by1, (ay2 < by2) ? ay2 : by2);
    aw <= span(ax1, ax2);
    ah <= span(ay1, ay2);
    bw <= span(bx1, bx2);
    bh <= span(by1, by2);
    inter2 <= iw * ih;
    area_a <= aw * ah;
    area_b <= bw * bh;
    inter3 <= inter2;
    uni    <= {1'b0, area_a} + {1'b0, area_b} - {1'b0, inter2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      thr           <= 17'd32768;
      presorted     <= 1'b0;
      box_count     <= '0;
      cnt           <= '0;
      overflow_seen <= 1'b0;
      done          <= '0;
      sc_v          <= 1'b0;
      cd_v          <= 1'b0;
      p1_v          <= 1'b0;
      p2_v          <= 1'b0;
      p3_v          <= 1'b0;
      found         <= 1'b0;
      pend_v        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr == ADDR_THR) begin
          thr <= pwdata[16:0];
        end else if (paddr == ADDR_PRESORT) begin
          presorted <= pwdata[0];
        end
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      sc_v <= sc_re;
      cd_v <= (state == ST_SUP) && (cnt < box_count);
      p1_v <= cd_v;
      p2_v <= p1_v;
      p3_v <= p2_v;

      // Max search: strict greater keeps the earliest of equal scores; presorted takes the first remaining box.
      if (sc_v && !done[sc_idx] && (!found || (!presorted && (sc_rdata > best_score)))) begin
        found      <= 1'b1;
        best_idx   <= sc_idx;
        best_score <= sc_rdata;
      end
      if (p3_v && !done[p3_idx] && over) begin
        done[p3_idx] <= 1'b1;
      end

      case (state)
        ST_LOAD: begin
          if (s_acc) begin
            if (box_count < CNT_W'(MAX_BOXES)) begin
              box_count <= box_count + 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
            if (s_axis_tlast) begin
              state <= ST_SCAN;
              cnt   <= '0;
              found <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (cnt < box_count) begin
            cnt <= cnt + 1'b1;
          end else begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          state <= found ? ST_FETCH : ST_FINAL;
        end
        ST_FETCH: begin
          done[best_idx] <= 1'b1;
          state          <= ST_FWAIT;
        end
        ST_FWAIT: begin
          if (!pend_v || out_free) begin
            if (pend_v) begin
              m_axis_tdata  <= {pend_score, pend_coord};
              m_axis_tlast  <= 1'b0;
              m_axis_tuser  <= overflow_seen;
            end
            pend_v     <= 1'b1;
            pend_coord <= cd_rdata;
            pend_score <= best_score;
            cnt        <= '0;
            state      <= ST_SUP;
          end
        end
        ST_SUP: begin
          if (cnt < box_count) begin
            cnt <= cnt + 1'b1;
          end else begin
            state <= ST_SDRAIN;
          end
        end
        ST_SDRAIN: begin
          if (!cd_v && !p1_v && !p2_v && !p3_v) begin
            state <= ST_SCAN;
            cnt   <= '0;
            found <= 1'b0;
          end
        end
        ST_FINAL: begin
          if (out_free) begin
            m_axis_tdata  <= {pend_score, pend_coord};
            m_axis_tlast  <= 1'b1;
            m_axis_tuser  <= overflow_seen;
            pend_v        <= 1'b0;
            done          <= '0;
            box_count     <= '0;
            overflow_seen <= 1'b0;
            state         <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

### design/gbn_checker.sv
// Port-level checks for the greedy box NMS block, bound to its top level.
// Depends on greedy_box_nms_top_defines.svh and greedy_box_nms_top.
`include "greedy_box_nms_top_defines.svh"

module gbn_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // A closing item starts processing, so the input closes at once.
  `GBN_ASSERT_NEXT(a_close_stalls_input, clk, rst, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input still open after batch close")
  // The last result of a batch is never directly followed by another one.
  `GBN_ASSERT_NEXT(a_gap_after_last, clk, rst, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid, "result right after last of batch")
  // While results are pending, no new batch is being loaded.
  `GBN_ASSERT_NOW(a_no_load_while_pending, clk, rst, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input open during processing")
  `GBN_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

endmodule

bind greedy_box_nms_top gbn_checker u_gbn_checker (.*);

### test/tb_greedy_box_nms_top.sv
// Testbench for the greedy box NMS block: loads batches of boxes over the input
// stream, predicts the surviving boxes and checks every result. Depends on gbn_pkg.
module tb_greedy_box_nms_top;
  import gbn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_THRESHOLD = 3'd0;
  localparam logic [2:0] ADDR_PRESORTED = 3'd4;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [15:0] lx, ty, rx, by, conf;
    logic        fin, trunc;
  } kept_box_t;

  typedef struct {
    logic signed [15:0] lx, ty, rx, by;
    logic [15:0]        conf;
  } box_t;

  class nms_scoreboard;
    box_t            batch[$];
    bit              dropped;
    logic [16:0]     threshold = 17'd32768;
    bit              presorted;
    kept_box_t       kept_q[$];
    int              errors;
    int              results_seen;

    function longint clamp0(longint v);
      return v > 0 ? v : 0;
    endfunction

    function bit suppresses(box_t a, box_t b);
      longint xl, yt, xr, yb, inter, uni;
      if (a.lx > b.rx || a.rx < b.lx || a.ty > b.by || a.by < b.ty) return 0;
      xl = a.lx > b.lx ? a.lx : b.lx;
      yt = a.ty > b.ty ? a.ty : b.ty;
      xr = a.rx < b.rx ? a.rx : b.rx;
      yb = a.by < b.by ? a.by : b.by;
      inter = clamp0(xr - xl) * clamp0(yb - yt);
      uni = clamp0(longint'(a.rx) - a.lx) * clamp0(longint'(a.by) - a.ty)
          + clamp0(longint'(b.rx) - b.lx) * clamp0(longint'(b.by) - b.ty) - inter;
      if (uni == 0) return 0;
      return inter * 65536 > longint'(threshold) * uni;
    endfunction

    function void note_box(box_t b, bit last);
      box_t      ord[$];
      bit        gone[$];
      kept_box_t k_item;
      int        j;
      if (batch.size() < MAX_BOXES) batch.insert(batch.size(), b);
      else dropped = 1;
      if (!last) return;
      foreach (batch[i]) begin
        j = ord.size();
        ord.insert(ord.size(), batch[i]);
        gone.insert(gone.size(), 1'b0);
        // Stable insertion: move only past strictly lower scores.
        while (!presorted && j > 0 && ord[j-1].conf < batch[i].conf) begin
          ord[j] = ord[j-1];
          j--;
        end
        ord[j] = batch[i];
      end
      foreach (ord[i]) begin
        if (gone[i]) continue;
        k_item = '{ord[i].lx, ord[i].ty, ord[i].rx, ord[i].by, ord[i].conf,
                   1'b0, dropped};
        kept_q.insert(kept_q.size(), k_item);
        for (int k = i + 1; k < ord.size(); k++)
          if (!gone[k] && suppresses(ord[i], ord[k])) gone[k] = 1;
      end
      kept_q[$].fin = 1'b1;
      batch.delete();
      dropped = 0;
    endfunction

    function void check_result(kept_box_t got);
      kept_box_t e;
      results_seen++;
      if (kept_q.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      e = kept_q.pop_front();
      if (got.lx != e.lx) begin $error("kept_left_x exp %h got %h", e.lx, got.lx); errors++; end
      if (got.ty != e.ty) begin $error("kept_top_y exp %h got %h", e.ty, got.ty); errors++; end
      if (got.rx != e.rx) begin $error("kept_right_x exp %h got %h", e.rx, got.rx); errors++; end
      if (got.by != e.by) begin $error("kept_bottom_y exp %h got %h", e.by, got.by); errors++; end
      if (got.conf != e.conf) begin
        $error("kept_confidence exp %h got %h", e.conf, got.conf); errors++;
      end
      if (got.fin != e.fin) begin $error("final_kept exp %b got %b", e.fin, got.fin); errors++; end
      if (got.trunc != e.trunc) begin
        $error("truncated exp %b got %b", e.trunc, got.trunc); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [79:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready, m_axis_tlast, m_axis_tuser;
  logic [79:0] m_axis_tdata;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  nms_scoreboard sb = new();
  int  cycles;
  int  boxes_sent;
  bit  sink_on;

  greedy_box_nms_top u_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result('{m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                        m_axis_tdata[63:48], m_axis_tdata[79:64], m_axis_tlast,
                        m_axis_tuser});
  end

  // Receiver with random stalls; tready drops again after every pulse, at times with no wait before the next.
  initial begin
    int wait_n;
    m_axis_tready = 0;
    forever begin
      @(negedge clk);
      if (!sink_on || m_axis_tready) begin
        m_axis_tready = 0;
        continue;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      repeat (wait_n) @(negedge clk);
      m_axis_tready = 1;
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel = 1; pwrite = 1; paddr = addr; pwdata = data; penable = 0;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic set_config(logic [16:0] thr, bit pre);
    reg_write(ADDR_THRESHOLD, 32'(thr));
    reg_write(ADDR_PRESORTED, 32'(pre));
    sb.threshold = thr;
    sb.presorted = pre;
  endtask

  task automatic send_box(box_t b, bit last, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 17);
    repeat (gap) @(negedge clk);
    s_axis_tvalid = 1;
    s_axis_tdata = {b.conf, b.by, b.rx, b.ty, b.lx};
    s_axis_tlast = last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_box(b, last);
    boxes_sent++;
    @(negedge clk);
    s_axis_tvalid = 0;
  endtask

  function automatic box_t rand_box(bit wild);
    box_t b;
    int cx, cy;
    if (wild) begin
      b = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    end else begin
      // Clustered boxes so that overlaps are common.
      cx = int'($urandom_range(0, 200)) - 100;
      cy = int'($urandom_range(0, 200)) - 100;
      b.lx = 16'(cx); b.ty = 16'(cy);
      b.rx = 16'(cx + int'($urandom_range(0, 60)));
      b.by = 16'(cy + int'($urandom_range(0, 60)));
      b.conf = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    end
    return b;
  endfunction

  task automatic send_batch(int n, bit no_gap);
    for (int i = 0; i < n; i++)
      send_box(rand_box($urandom_range(0, 9) == 0), i == n - 1, no_gap);
  endtask

  task automatic drain;
    while (sb.kept_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    rst = 1; s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tlast = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    sink_on = 1;
    repeat (5) @(posedge clk);
    @(negedge clk) rst = 0;

    // Directed: extremes, identical boxes, inverted and disjoint boxes.
    send_box('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'hffff}, 0, 0);
    send_box('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'h0000}, 0, 0);
    send_box('{16'sd10, 16'sd10, -16'sd10, -16'sd10, 16'h8000}, 0, 0);
    send_box('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h8000}, 0, 0);
    send_box('{16'sd100, 16'sd100, 16'sd110, 16'sd110, 16'h8000}, 1, 0);
    send_box('{16'sd5, 16'sd5, 16'sd9, 16'sd9, 16'h1234}, 1, 0);
    drain();
    set_config(17'd0, 1);
    send_batch(6, 1);
    drain();
    set_config(17'd65536, 0);
    send_batch(5, 0);
    drain();
    // Overflow: the closing item itself is dropped.
    set_config(17'd32768, 0);
    send_batch(MAX_BOXES + 3, 1);
    drain();

    // Random batches, mostly small, across several thresholds.
    while (boxes_sent < 150) begin
      set_config(($urandom_range(0, 5) == 0) ? 17'($urandom_range(65537, 131071))
                                             : 17'($urandom_range(0, 65536)),
                 $urandom_range(0, 1));
      for (int k = 0; k < 4; k++)
        send_batch(($urandom_range(0, 4) == 0) ? $urandom_range(1, 20)
                                               : $urandom_range(1, 6),
                   $urandom_range(0, 3) == 0);
      drain();
    end

    $display("Covered %0d boxes and %0d kept results over several threshold settings,",
             boxes_sent, sb.results_seen);
    $display("including presorted mode, overflowed batches and degenerate boxes.");
    if (sb.errors == 0 && sb.kept_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

### greedy_box_nms_top.f
+incdir+design
design/gbn_pkg.sv
design/greedy_box_nms_top.sv
design/gbn_checker.sv
test/tb_greedy_box_nms_top.sv
